[rtl/free_list_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Free list allocator assertion macros
// Assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define FLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("free list allocator assertion failed");
// The condition must never be true at a clock edge outside reset.
`define FLA_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("free list allocator forbidden condition seen");
`else
`define FLA_ASSERT(lbl, clk, rst_n, prop)
`define FLA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/fla_pkg.sv]
// ----------------------------------------------------------------------------
// Free list allocator package
// Field widths and the codes shared by the allocator modules.
// ----------------------------------------------------------------------------
package fla_pkg;

  // Field widths of the request and result.
  localparam int unsigned BYTES_W   = 21;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FIT_W     = 2;
  localparam int unsigned MINGROW_W = 17;
  // Byte count rounded up, and the width of the unit arithmetic.
  localparam int unsigned NEED_W    = BYTES_W + 1;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

  // Fit strategies; any other code searches first fit.
  localparam logic [FIT_W-1:0] FIT_FIRST = 2'd1;
  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd2;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FIT  = 1'b0;
  localparam logic CFG_GROW = 1'b1;

  // Register reset values.
  localparam logic [MINGROW_W-1:0] GROW_RESET = 17'd1024;

endpackage

[rtl/free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Free list allocator
// Address-ordered circular free list with first, best and worst fit search.
// ----------------------------------------------------------------------------
// One request is worked on at a time; its result goes to an output register so
// the next request is taken while the result waits. All block headers live in
// one header memory with a single read port and registered read data, so each
// free list entry visited takes a read state and a judge state. An allocate
// sizes the request in the divider, reads the search start, searches the list
// entry by entry, grows the arena when no block fits, then unlinks or cuts the
// block and hands over the result. A free walks to its place in address order
// and merges with its neighbours when they touch. A null or zero-size request
// goes straight to the result. There is no clearing pass after reset.
`include "free_list_allocator_macros.svh"

module free_list_allocator #(
  parameter int unsigned HEAP_UNITS = 65536,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [fla_pkg::MINGROW_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [fla_pkg::BYTES_W-1:0]   request_bytes_i,
  input  logic [fla_pkg::ADDR_W-1:0]    block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fla_pkg::ADDR_W-1:0]    result_address_o,
  output logic [fla_pkg::STATUS_W-1:0]  status_o
);
  import fla_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned DW = AW + UW;
  localparam int unsigned WW = NEED_W;
  localparam logic [WW-1:0]   HEAP_W      = WW'(HEAP_UNITS);
  localparam logic [WW-1:0]   ROUND_UP    = WW'(UNIT_BYTES - 1);
  localparam logic [AW+2:0]   STEP_LIMIT  = (AW+3)'(2 * HEAP_UNITS + 4);
  localparam logic [AW+1:0]   ISTEP_LIMIT = (AW+2)'(HEAP_UNITS);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_START  = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_A0_RD  = 5'd3;
  localparam logic [4:0] S_A0     = 5'd4;
  localparam logic [4:0] S_AW_RD  = 5'd5;
  localparam logic [4:0] S_AW     = 5'd6;
  localparam logic [4:0] S_GROW   = 5'd7;
  localparam logic [4:0] S_A_END  = 5'd8;
  localparam logic [4:0] S_SPLIT  = 5'd9;
  localparam logic [4:0] S_I_RD   = 5'd10;
  localparam logic [4:0] S_I      = 5'd11;
  localparam logic [4:0] S_IH_RD  = 5'd12;
  localparam logic [4:0] S_IH     = 5'd13;
  localparam logic [4:0] S_IN_RD  = 5'd14;
  localparam logic [4:0] S_IN     = 5'd15;
  localparam logic [4:0] S_IP     = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  // Payload unit index of a header, cut to the result width.
  function automatic logic [ADDR_W-1:0] to_addr(input logic [AW-1:0] hdr);
    logic [WW-1:0] w;
    w = WW'(hdr) + WW'(1);
    return w[ADDR_W-1:0];
  endfunction

  // Control state.
  logic [4:0]           state_q, state_d;
  logic                 started_q, started_d;
  logic [AW-1:0]        fs_q, fs_d;
  logic [UW-1:0]        arena_q, arena_d;
  logic [FIT_W-1:0]     strat_q, strat_d;
  logic [MINGROW_W-1:0] mingrow_q, mingrow_d;
  logic                 out_valid_q, out_valid_d;

  // Working registers.
  logic                 op_q, op_d;
  logic [BYTES_W-1:0]   bytes_q, bytes_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [WW-1:0]        need_q, need_d;
  logic [AW-1:0]        h_q, h_d;
  logic                 ret_q, ret_d;
  logic [AW-1:0]        p_q, p_d;
  logic [AW-1:0]        prev_q, prev_d;
  logic [UW-1:0]        prev_units_q, prev_units_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        pick_q, pick_d;
  logic [AW-1:0]        pick_prev_q, pick_prev_d;
  logic [AW-1:0]        pick_link_q, pick_link_d;
  logic [UW-1:0]        pick_size_q, pick_size_d;
  logic [UW-1:0]        pick_prev_units_q, pick_prev_units_d;
  logic [AW+2:0]        steps_q, steps_d;
  logic [AW+1:0]        isteps_q, isteps_d;
  logic [AW-1:0]        plink_q, plink_d;
  logic [UW-1:0]        punits_q, punits_d;
  logic [UW-1:0]        hunits_q, hunits_d;
  logic [AW-1:0]        hn_link_q, hn_link_d;
  logic [UW-1:0]        hn_units_q, hn_units_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;

  // Memory and divider connections.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0] rd_link;
  logic [UW-1:0] rd_units;
  logic          div_start, div_done;
  logic [WW-1:0] div_quot;
  logic [WW-1:0] div_in;
  logic [ADDR_W-1:0] addr_m1;
  logic [WW-1:0] hx;

  assign rd_link  = mem_rdata[DW-1:UW];
  assign rd_units = mem_rdata[UW-1:0];
  assign div_in   = WW'(bytes_q) + ROUND_UP;
  assign addr_m1  = addr_q - ADDR_W'(1);
  assign hx       = WW'(addr_m1);

  fla_mem #(
    .DEPTH (HEAP_UNITS),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fla_div #(
    .UNIT_BYTES (UNIT_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer: list walks, growth, split and merge.
  always_comb begin
    logic          hit, take, brk;
    logic [UW-1:0] size_n, eunits, rest;
    logic [WW-1:0] nu;
    logic [AW-1:0] newh;
    state_d = state_q;       started_d = started_q;   fs_d = fs_q;
    arena_d = arena_q;       strat_d = strat_q;       mingrow_d = mingrow_q;
    out_valid_d = out_valid_q;
    op_d = op_q;             bytes_d = bytes_q;       addr_d = addr_q;
    need_d = need_q;         h_d = h_q;               ret_d = ret_q;
    p_d = p_q;               prev_d = prev_q;         prev_units_d = prev_units_q;
    found_d = found_q;       pick_d = pick_q;         pick_prev_d = pick_prev_q;
    pick_link_d = pick_link_q;  pick_size_d = pick_size_q;
    pick_prev_units_d = pick_prev_units_q;
    steps_d = steps_q;       isteps_d = isteps_q;
    plink_d = plink_q;       punits_d = punits_q;     hunits_d = hunits_q;
    hn_link_d = hn_link_q;   hn_units_d = hn_units_q;
    res_addr_d = res_addr_q; res_status_d = res_status_q;
    out_addr_d = out_addr_q; out_status_d = out_status_q;
    mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = p_q;
    div_start = 1'b0;
    hit = 1'b0;  take = 1'b0;  brk = 1'b0;
    size_n = '0;  eunits = '0;  rest = '0;  nu = '0;  newh = '0;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIT:  strat_d   = cfg_wdata_i[FIT_W-1:0];
        CFG_GROW: mingrow_d = cfg_wdata_i;
        default:  strat_d   = strat_q;
      endcase
    end

    // The output register empties when its result is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          bytes_d = request_bytes_i;
          addr_d  = block_address_i;
          state_d = S_START;
        end
      end

      // Start the list on first use, then sort out trivial requests.
      S_START: begin
        if (!started_q) begin
          mem_we    = 1'b1;
          fs_d      = '0;
          started_d = 1'b1;
        end
        res_addr_d = '0;
        if (op_q == OP_FREE) begin
          if (addr_q == '0 || hx == '0 || hx >= WW'(arena_q)) begin
            res_status_d = ST_NOP;
            state_d      = S_DONE;
          end else begin
            h_d      = hx[AW-1:0];
            ret_d    = 1'b0;
            p_d      = started_q ? fs_q : '0;
            isteps_d = '0;
            state_d  = S_I_RD;
          end
        end else if (bytes_q == '0) begin
          res_status_d = ST_NOP;
          state_d      = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          need_d      = div_quot + WW'(1);
          prev_d      = fs_q;
          found_d     = 1'b0;
          pick_size_d = '0;
          steps_d     = '0;
          state_d     = S_A0_RD;
        end
      end

      // Read the entry the search starts behind.
      S_A0_RD: begin
        mem_raddr = prev_q;
        state_d   = S_A0;
      end

      S_A0: begin
        prev_units_d = rd_units;
        p_d          = rd_link;
        state_d      = S_AW_RD;
      end

      S_AW_RD: begin
        mem_raddr = p_q;
        state_d   = (steps_q >= STEP_LIMIT) ? S_A_END : S_AW;
      end

      // Judge one free block against the strategy.
      S_AW: begin
        hit = WW'(rd_units) >= need_q;
        priority case (strat_q)
          FIT_BEST: begin
            take   = hit && (!found_q || rd_units < pick_size_q);
            size_n = take ? rd_units : pick_size_q;
            brk    = hit && (WW'(size_n) == need_q);
          end
          FIT_WORST: begin
            take = hit && (rd_units > pick_size_q);
            brk  = 1'b0;
          end
          default: begin
            take = hit;
            brk  = hit;
          end
        endcase
        if (take) begin
          found_d           = 1'b1;
          pick_d            = p_q;
          pick_prev_d       = prev_q;
          pick_size_d       = rd_units;
          pick_link_d       = rd_link;
          pick_prev_units_d = prev_units_q;
        end
        if (brk) begin
          state_d = S_A_END;
        end else if (p_q == fs_q) begin
          state_d = (found_q || take) ? S_A_END : S_GROW;
        end else begin
          prev_d       = p_q;
          prev_units_d = rd_units;
          p_d          = rd_link;
          steps_d      = steps_q + (AW+3)'(1);
          state_d      = S_AW_RD;
        end
      end

      // Add a fresh block at the end of the arena and free it.
      S_GROW: begin
        nu = (need_q > WW'(mingrow_q)) ? need_q : WW'(mingrow_q);
        if (WW'(arena_q) > HEAP_W || nu > HEAP_W - WW'(arena_q)) begin
          res_status_d = ST_OOM;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = arena_q[AW-1:0];
          mem_wdata = {{AW{1'b0}}, nu[UW-1:0]};
          h_d       = arena_q[AW-1:0];
          arena_d   = arena_q + nu[UW-1:0];
          steps_d   = steps_q + (AW+3)'(1);
          ret_d     = 1'b1;
          p_d       = fs_q;
          isteps_d  = '0;
          state_d   = S_I_RD;
        end
      end

      // Unlink an exact fit or cut the tail off a larger block; fail when none was found.
      S_A_END: begin
        if (!found_q) begin
          res_status_d = ST_OOM;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else if (WW'(pick_size_q) == need_q) begin
          mem_we       = 1'b1;
          mem_waddr    = pick_prev_q;
          mem_wdata    = {pick_link_q, pick_prev_units_q};
          fs_d         = pick_prev_q;
          res_addr_d   = to_addr(pick_q);
          res_status_d = ST_DONE;
          state_d      = S_DONE;
        end else begin
          rest        = pick_size_q - need_q[UW-1:0];
          mem_we      = 1'b1;
          mem_waddr   = pick_q;
          mem_wdata   = {pick_link_q, rest};
          pick_size_d = rest;
          state_d     = S_SPLIT;
        end
      end

      S_SPLIT: begin
        newh         = pick_q + pick_size_q[AW-1:0];
        mem_we       = 1'b1;
        mem_waddr    = newh;
        mem_wdata    = {{AW{1'b0}}, need_q[UW-1:0]};
        fs_d         = pick_prev_q;
        res_addr_d   = to_addr(newh);
        res_status_d = ST_DONE;
        state_d      = S_DONE;
      end

      // Walk to the place of the freed block in address order.
      S_I_RD: begin
        mem_raddr = p_q;
        state_d   = S_I;
      end

      S_I: begin
        if ((h_q > p_q && h_q < rd_link) ||
            (p_q >= rd_link && (h_q > p_q || h_q < rd_link))) begin
          plink_d  = rd_link;
          punits_d = rd_units;
          state_d  = S_IH_RD;
        end else if (isteps_q > ISTEP_LIMIT) begin
          res_status_d = ret_q ? ST_OOM : ST_NOP;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else begin
          p_d      = rd_link;
          isteps_d = isteps_q + (AW+2)'(1);
          state_d  = S_I_RD;
        end
      end

      S_IH_RD: begin
        mem_raddr = h_q;
        state_d   = S_IH;
      end

      S_IH: begin
        hunits_d = rd_units;
        state_d  = S_IN_RD;
      end

      S_IN_RD: begin
        mem_raddr = plink_q;
        state_d   = S_IN;
      end

      // Merge with the following block when they touch.
      S_IN: begin
        if (WW'(h_q) + WW'(hunits_q) == WW'(plink_q)) begin
          hn_link_d  = rd_link;
          hn_units_d = hunits_q + rd_units;
        end else begin
          hn_link_d  = plink_q;
          hn_units_d = hunits_q;
        end
        mem_we    = 1'b1;
        mem_waddr = h_q;
        mem_wdata = {hn_link_d, hn_units_d};
        state_d   = S_IP;
      end

      // Merge with the preceding block when they touch.
      S_IP: begin
        eunits    = (p_q == h_q) ? hn_units_q : punits_q;
        mem_we    = 1'b1;
        mem_waddr = p_q;
        if (WW'(p_q) + WW'(eunits) == WW'(h_q)) begin
          mem_wdata = {hn_link_q, eunits + hn_units_q};
        end else begin
          mem_wdata = {h_q, eunits};
        end
        fs_d = p_q;
        if (ret_q) begin
          prev_d  = p_q;
          state_d = S_A0_RD;
        end else begin
          res_status_d = ST_DONE;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      fs_q        <= '0;
      arena_q     <= UW'(1);
      strat_q     <= FIT_FIRST;
      mingrow_q   <= GROW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      fs_q        <= fs_d;
      arena_q     <= arena_d;
      strat_q     <= strat_d;
      mingrow_q   <= mingrow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    op_q              <= op_d;
    bytes_q           <= bytes_d;
    addr_q            <= addr_d;
    need_q            <= need_d;
    h_q               <= h_d;
    ret_q             <= ret_d;
    p_q               <= p_d;
    prev_q            <= prev_d;
    prev_units_q      <= prev_units_d;
    found_q           <= found_d;
    pick_q            <= pick_d;
    pick_prev_q       <= pick_prev_d;
    pick_link_q       <= pick_link_d;
    pick_size_q       <= pick_size_d;
    pick_prev_units_q <= pick_prev_units_d;
    steps_q           <= steps_d;
    isteps_q          <= isteps_d;
    plink_q           <= plink_d;
    punits_q          <= punits_d;
    hunits_q          <= hunits_d;
    hn_link_q         <= hn_link_d;
    hn_units_q        <= hn_units_d;
    res_addr_q        <= res_addr_d;
    res_status_q      <= res_status_d;
    out_addr_q        <= out_addr_d;
    out_status_q      <= out_status_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;

  // Checks on the sequencer.
  `FLA_ASSERT(a_arena_bound, clk_i, rst_ni, arena_q <= UW'(HEAP_UNITS) && arena_q != '0)
  `FLA_ASSERT(a_fail_no_addr, clk_i, rst_ni, out_valid_o && status_o != ST_DONE |-> result_address_o == '0)
  `FLA_NEVER(a_idle_no_write, clk_i, rst_ni, state_q == S_IDLE && mem_we)
  `FLA_ASSERT(a_started_sticky, clk_i, rst_ni, started_q |=> started_q)

endmodule

[rtl/fla_mem.sv]
// ----------------------------------------------------------------------------
// Free list allocator header memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module fla_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned DW    = 33,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fla_div.sv]
// ----------------------------------------------------------------------------
// Free list allocator unit divider
// Division by the unit size through a reciprocal multiply, result registered.
// ----------------------------------------------------------------------------
module fla_div #(
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fla_pkg::NEED_W-1:0]  dividend_i,
  output logic                        done_o,
  output logic [fla_pkg::NEED_W-1:0]  quotient_o
);
  import fla_pkg::*;

  // With SHIFT = NEED_W + ceil(log2(UNIT_BYTES)) and RECIP = ceil(2**SHIFT / UNIT_BYTES),
  // (x * RECIP) >> SHIFT equals x / UNIT_BYTES for every NEED_W bit dividend.
  localparam int unsigned     SHIFT   = NEED_W + $clog2(UNIT_BYTES);
  localparam int unsigned     RW      = NEED_W + 1;
  localparam int unsigned     PW      = NEED_W + RW;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);

  logic              done_q;
  logic [NEED_W-1:0] quo_q;
  logic [PW-1:0]     prod;

  // Full product of the dividend and the reciprocal.
  assign prod = PW'(dividend_i) * PW'(RECIP);

  // The quotient is ready in the cycle after start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // Quotient register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= NEED_W'(prod >> SHIFT);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
